>>> sv/lrm_pkg.sv
// Shared types, constants and modular arithmetic helpers for the
// lazy range multiply/add/sum block. No dependencies.
package lrm_pkg;

   localparam int LRM_MAX_ELEMENTS = 65536;
   localparam int LRM_IDX_W        = 17;
   localparam int LRM_VAL_W        = 31;
   localparam int LRM_QUEUE_DEPTH  = 2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_MUL   = 2'd1,
      OP_ADD   = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   localparam logic [1:0] CSR_MODULUS = 2'd0;
   localparam logic [1:0] CSR_COUNT   = 2'd1;

   typedef struct packed {
      op_type                 op;
      logic                   skip;
      logic [LRM_IDX_W-1:0]   lo;
      logic [LRM_IDX_W-1:0]   hi;
      logic [LRM_VAL_W-1:0]   operand;
   } cmd_type;

   // (a + b) mod m, with a, b < m
   function automatic logic [LRM_VAL_W-1:0] mod_add(input logic [LRM_VAL_W-1:0] a,
                                                    input logic [LRM_VAL_W-1:0] b,
                                                    input logic [LRM_VAL_W-1:0] m);
      logic [LRM_VAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[LRM_VAL_W-1:0];
   endfunction

   // (2r + x) mod m, with r < m and x <= m
   function automatic logic [LRM_VAL_W-1:0] mod_dbl_add(input logic [LRM_VAL_W-1:0] r,
                                                        input logic [LRM_VAL_W-1:0] x,
                                                        input logic [LRM_VAL_W-1:0] m);
      logic [LRM_VAL_W+1:0] t;
      logic [LRM_VAL_W+1:0] m1;
      logic [LRM_VAL_W+1:0] m2;
      t  = {1'b0, r, 1'b0} + {2'b0, x};
      m1 = {2'b0, m};
      m2 = {1'b0, m, 1'b0};
      if (t >= m2) begin
         t = t - m2;
      end else if (t >= m1) begin
         t = t - m1;
      end
      return t[LRM_VAL_W-1:0];
   endfunction

endpackage

>>> sv/lazy_range_mul_add_sum_mod.sv
// Top level of the range multiply/add/sum block: configuration registers,
// front end, command queue and back end. Depends on lrm_pkg, lrm_front,
// lrm_queue and lrm_back.
//
//  channel | ports                                    | transfer
//  --------+------------------------------------------+---------------------
//  request | req_valid/ready, req_type, req_range_*,  | valid & ready
//          | req_operand                              |
//  result  | rsp_valid/ready, rsp_range_sum           | valid & ready
//  config  | csr_we, csr_index, csr_wdata             | csr_we, no wait
//
// Each request passes the front register and the queue. The back end then
// reduces the operand in a 31-step serial pass; a load writes the result,
// while multiply, add and query walk the clamped range, reading each element
// from the single-port element memory through a registered read. Multiply
// runs each element through the 31-step serial modular multiplier.
// Reset, and any write to modulus or element_count, starts a clearing pass
// over the elements during which no request leaves the queue.
// Up to three request transactions buffer ahead of the back end; a result
// waits in the output register while the next request is taken.
module lazy_range_mul_add_sum_mod #(
   parameter int MAX_ELEMENTS = lrm_pkg::LRM_MAX_ELEMENTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [lrm_pkg::LRM_IDX_W-1:0] req_range_low,
   input  logic [lrm_pkg::LRM_IDX_W-1:0] req_range_high,
   input  logic [lrm_pkg::LRM_VAL_W-1:0] req_operand,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lrm_pkg::LRM_VAL_W-1:0] rsp_range_sum,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [lrm_pkg::LRM_VAL_W-1:0] csr_wdata
);
   import lrm_pkg::*;

   logic [LRM_VAL_W-1:0] modulus_ff, modulus_in;
   logic [LRM_IDX_W-1:0] count_ff, count_in;
   logic [LRM_VAL_W-1:0] mod_eff;
   logic [LRM_IDX_W-1:0] n_eff;
   logic                 csr_hit;

   logic                 f_valid, f_ready, q_valid, q_ready;
   cmd_type              f_cmd, q_cmd;

   // Only the two defined registers wipe the element memory; other indexes drop.
   assign csr_hit = csr_we && (csr_index == CSR_MODULUS || csr_index == CSR_COUNT);

   always_comb begin
      modulus_in = modulus_ff;
      count_in   = count_ff;
      if (csr_we && csr_index == CSR_MODULUS) begin
         modulus_in = csr_wdata;
      end
      if (csr_we && csr_index == CSR_COUNT) begin
         count_in = csr_wdata[LRM_IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= LRM_VAL_W'(2147483647);
         count_ff   <= LRM_IDX_W'(65536);
      end else begin
         modulus_ff <= modulus_in;
         count_ff   <= count_in;
      end
   end

   // Zero modulus acts as one; element count saturates to [1, MAX_ELEMENTS].
   always_comb begin
      mod_eff = (modulus_ff == '0) ? LRM_VAL_W'(1) : modulus_ff;
      if (count_ff == '0) begin
         n_eff = LRM_IDX_W'(1);
      end else if (32'(count_ff) > 32'(MAX_ELEMENTS)) begin
         n_eff = LRM_IDX_W'(MAX_ELEMENTS);
      end else begin
         n_eff = count_ff;
      end
   end

   lrm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .req_operand    (req_operand),
      .elem_count     (n_eff),
      .cmd_valid      (f_valid),
      .cmd            (f_cmd),
      .cmd_ready      (f_ready)
   );

   lrm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   lrm_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .clear         (csr_hit),
      .modulus       (mod_eff),
      .elem_count    (n_eff),
      .cmd_valid     (q_valid),
      .cmd_ready     (q_ready),
      .cmd           (q_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_range_sum (rsp_range_sum)
   );

endmodule

>>> sv/lrm_front.sv
// Front end: accepts request transactions, clamps ranges and flags no-op
// requests. Depends on lrm_pkg.
module lrm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [lrm_pkg::LRM_IDX_W-1:0] req_range_low,
   input  logic [lrm_pkg::LRM_IDX_W-1:0] req_range_high,
   input  logic [lrm_pkg::LRM_VAL_W-1:0] req_operand,
   input  logic [lrm_pkg::LRM_IDX_W-1:0] elem_count,
   output logic                          cmd_valid,
   output lrm_pkg::cmd_type              cmd,
   input  logic                          cmd_ready
);
   import lrm_pkg::*;

   logic                 cmd_valid_ff, cmd_valid_in;
   cmd_type              cmd_ff, cmd_in;
   logic [LRM_IDX_W-1:0] lo_c, hi_c;

   assign req_ready = !cmd_valid_ff || cmd_ready;
   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      lo_c = (req_range_low == '0) ? LRM_IDX_W'(1) : req_range_low;
      hi_c = (req_range_high > elem_count) ? elem_count : req_range_high;
      cmd_in         = cmd_ff;
      cmd_valid_in   = cmd_valid_ff;
      if (cmd_ready) begin
         cmd_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         cmd_valid_in   = 1'b1;
         cmd_in.op      = op_type'(req_type);
         cmd_in.operand = req_operand;
         if (op_type'(req_type) == OP_LOAD) begin
            cmd_in.lo   = req_range_low;
            cmd_in.hi   = req_range_low;
            cmd_in.skip = (req_range_low == '0) || (req_range_low > elem_count);
         end else begin
            cmd_in.lo   = lo_c;
            cmd_in.hi   = hi_c;
            cmd_in.skip = lo_c > hi_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

>>> sv/lrm_queue.sv
// Two-entry command queue between front and back end.
// Depends on lrm_pkg.
module lrm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  lrm_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output lrm_pkg::cmd_type pop_cmd
);
   import lrm_pkg::*;

   localparam int PW = $clog2(LRM_QUEUE_DEPTH);
   localparam int CW = $clog2(LRM_QUEUE_DEPTH + 1);

   cmd_type         entry_ff [LRM_QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign push_ready = count_ff != CW'(LRM_QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(LRM_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(LRM_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> sv/lrm_back.sv
// Back end: element memory, serial modular multiplier and the sequencer
// that walks each range. Depends on lrm_pkg.
module lrm_back #(
   parameter int MAX_ELEMENTS = lrm_pkg::LRM_MAX_ELEMENTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic [lrm_pkg::LRM_VAL_W-1:0] modulus,
   input  logic [lrm_pkg::LRM_IDX_W-1:0] elem_count,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  lrm_pkg::cmd_type              cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lrm_pkg::LRM_VAL_W-1:0] rsp_range_sum
);
   import lrm_pkg::*;

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int BW = $clog2(LRM_VAL_W);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_REDUCE = 7'b0000100,
      S_READ   = 7'b0001000,
      S_OP     = 7'b0010000,
      S_MUL    = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   logic [LRM_VAL_W-1:0] mem [MAX_ELEMENTS];

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic                 skip_ff, skip_in;
   logic [LRM_IDX_W-1:0] hi_ff, hi_in, lo_ff, lo_in, idx_ff, idx_in;
   logic [LRM_VAL_W-1:0] k_ff, k_in, acc_ff, acc_in, r_ff, r_in, x_ff, x_in, y_ff, y_in;
   logic [BW-1:0]        cnt_ff, cnt_in;
   logic [LRM_VAL_W-1:0] rd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LRM_VAL_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                 mem_we;
   logic [LRM_VAL_W-1:0] mem_wd, step;
   logic [LRM_IDX_W-1:0] idx_m1;
   logic [AW-1:0]        addr;
   logic                 last;

   assign idx_m1        = idx_ff - LRM_IDX_W'(1);
   assign addr          = AW'(idx_m1);
   assign step          = mod_dbl_add(r_ff, y_ff[cnt_ff] ? x_ff : '0, modulus);
   assign last          = idx_ff == hi_ff;
   assign cmd_ready     = state_ff == S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      skip_in      = skip_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      r_in         = r_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_wd       = step;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = '0;
            if (idx_ff >= elem_count) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + LRM_IDX_W'(1);
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               op_in    = cmd.op;
               skip_in  = cmd.skip;
               lo_in    = cmd.lo;
               hi_in    = cmd.hi;
               idx_in   = cmd.lo;
               y_in     = cmd.operand;
               x_in     = LRM_VAL_W'(1);
               r_in     = '0;
               acc_in   = '0;
               cnt_in   = BW'(LRM_VAL_W - 1);
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            r_in = step;
            if (cnt_ff == '0) begin
               k_in = step;
               if (skip_ff) begin
                  state_in = (op_ff == OP_QUERY) ? S_RESP : S_IDLE;
               end else if (op_ff == OP_LOAD) begin
                  mem_we   = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end else begin
               cnt_in = cnt_ff - BW'(1);
            end
         end
         S_READ: begin
            state_in = S_OP;
         end
         S_OP: begin
            if (op_ff == OP_MUL) begin
               x_in     = rd_data_ff;
               y_in     = k_ff;
               r_in     = '0;
               cnt_in   = BW'(LRM_VAL_W - 1);
               state_in = S_MUL;
            end else begin
               if (op_ff == OP_ADD) begin
                  mem_we = 1'b1;
                  mem_wd = mod_add(rd_data_ff, k_ff, modulus);
               end else begin
                  acc_in = mod_add(acc_ff, rd_data_ff, modulus);
               end
               if (last) begin
                  state_in = (op_ff == OP_QUERY) ? S_RESP : S_IDLE;
               end else begin
                  idx_in   = idx_ff + LRM_IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         S_MUL: begin
            r_in = step;
            if (cnt_ff == '0) begin
               mem_we = 1'b1;
               if (last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + LRM_IDX_W'(1);
                  state_in = S_READ;
               end
            end else begin
               cnt_in = cnt_ff - BW'(1);
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      if (clear) begin
         state_in = S_CLEAR;
         idx_in   = LRM_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= LRM_IDX_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      skip_ff    <= skip_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      k_ff       <= k_in;
      acc_ff     <= acc_in;
      r_ff       <= r_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      cnt_ff     <= cnt_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= mem_wd;
      end
      rd_data_ff <= mem[addr];
   end

`ifndef SYNTHESIS
   a_residue_below_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REDUCE || state_ff == S_MUL) |-> r_ff < modulus)
      else $error("serial residue not reduced");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> (idx_ff >= lo_ff && idx_ff <= hi_ff))
      else $error("range walk left its bounds");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP)
      else $error("result raised outside response step");
`endif

endmodule
